[rtl/gtie_pkg.sv]
// Shared constants, types and the per-level digit step for the tile index encoder.
`timescale 1ns / 1ps
`default_nettype none
package gtie_pkg;

  localparam int TILING    = 10;
  localparam int MAX_LEVEL = 9;
  localparam int NCELL     = MAX_LEVEL + 1;

  localparam int FRAC_W = 33;
  localparam int LVL_W  = 4;
  localparam int DIG_W  = 4;
  localparam int PROD_W = FRAC_W + $clog2(TILING + 1);
  localparam int HI_W   = PROD_W - 32;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(64'd1 << 32);

  // Token handed from cell to cell: remaining fractions and level bookkeeping.
  typedef struct packed {
    logic              empty;
    logic [FRAC_W-1:0] lat;
    logic [FRAC_W-1:0] lon;
    logic [LVL_W-1:0]  lvl;
    logic [LVL_W-1:0]  left;
  } tok_t;

  // One result as produced by a cell.
  typedef struct packed {
    logic             vld;
    logic [LVL_W-1:0] lvl;
    logic [DIG_W-1:0] row;
    logic [DIG_W-1:0] col;
    logic             empty;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [DIG_W-1:0]  digit;
    logic [FRAC_W-1:0] frac;
  } step_t;

  // digit = floor(f * TILING), clamped; the fraction keeps the remainder.
  function automatic step_t frac_step(input logic [FRAC_W-1:0] f);
    logic [PROD_W-1:0] prod;
    logic [HI_W-1:0]   hi;
    logic [DIG_W-1:0]  d;
    step_t             s;
    prod = PROD_W'(f) * PROD_W'(TILING);
    hi   = prod[PROD_W-1:32];
    if (hi > HI_W'(TILING - 1)) begin
      d = DIG_W'(TILING - 1);
    end else begin
      d = DIG_W'(hi);
    end
    s.digit = d;
    s.frac  = FRAC_W'(prod - (PROD_W'(d) << 32));
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/gtie_cell.sv]
// One level cell: holds a token, forms its digit pair and hands the remainder on.
`timescale 1ns / 1ps
`default_nettype none
module gtie_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ld,
  input  wire logic          vld_i,
  input  wire gtie_pkg::tok_t tok_i,
  output logic               vld_o,
  output gtie_pkg::tok_t     tok_o,
  output gtie_pkg::res_t     res_o
);
  import gtie_pkg::*;

  logic  vld_r;
  tok_t  dat_r;
  step_t lat_s;
  step_t lon_s;
  logic  last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dat_r <= tok_i;
    end
  end

  always_comb begin
    lat_s = frac_step(dat_r.lat);
    lon_s = frac_step(dat_r.lon);
    last  = dat_r.empty | (dat_r.left == '0);

    res_o.vld   = vld_r;
    res_o.lvl   = dat_r.empty ? '0 : dat_r.lvl;
    res_o.row   = dat_r.empty ? '0 : lat_s.digit;
    res_o.col   = dat_r.empty ? '0 : lon_s.digit;
    res_o.empty = dat_r.empty;
    res_o.last  = last;

    vld_o       = vld_r & ~last;
    tok_o.empty = 1'b0;
    tok_o.lat   = lat_s.frac;
    tok_o.lon   = lon_s.frac;
    tok_o.lvl   = dat_r.lvl + LVL_W'(1);
    tok_o.left  = dat_r.left - LVL_W'(1);
  end

endmodule
`default_nettype wire

[rtl/geo_tile_index_encoder.sv]
// Top level: hierarchical lat/lon tile index encoder built as a chain of level cells.
//
// Input stream: in_tdata carries lat_pos, lon_pos and level; in_tuser is
// has_position. Each accepted transaction yields level+1 results (level is
// saturated to MAX_LEVEL), one per tile level from 0 upward, the final one
// with out_tlast set. Without a position a single result with out_tuser
// (empty) and out_tlast set and all digits zero is produced.
// Fractions above 2^32 are treated as 2^32.
// The item enters the first cell; each cycle the output advances, the token steps
// one cell down the chain, and the cell holding it drives the next result into
// the output register. The first result passes the first cell's register and
// then the output register. in_tready is high only while the chain is empty.
// A stalled receiver (out_tready low with out_tvalid high) freezes the chain
// and the output register, but an empty chain's first cell still takes a new item.
// Reset clears the chain and output valid; no results are pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
module geo_tile_index_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // lat_pos[32:0], lon_pos[65:33], level[69:66]
  input  wire logic        in_tuser,  // has_position
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // tile_level[3:0], row_digit[7:4], col_digit[11:8]
  output logic             out_tuser, // empty_res
  output logic             out_tlast
);
  import gtie_pkg::*;

  logic              in_acc;
  logic              adv;
  logic              busy;
  logic              cin_vld  [NCELL];
  tok_t              cin_tok  [NCELL];
  logic              cout_vld [NCELL];
  tok_t              cout_tok [NCELL];
  res_t              cres     [NCELL];
  res_t              sel;
  logic [FRAC_W-1:0] lat_in;
  logic [FRAC_W-1:0] lon_in;
  logic [LVL_W-1:0]  lvl_in;

  logic              out_valid_r;
  res_t              out_res_r;

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = ~busy;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    lat_in = in_tdata[32:0];
    lon_in = in_tdata[65:33];
    lvl_in = in_tdata[69:66];
    if (lat_in > FRAC_ONE) lat_in = FRAC_ONE;
    if (lon_in > FRAC_ONE) lon_in = FRAC_ONE;
    if (lvl_in > LVL_W'(MAX_LEVEL)) lvl_in = LVL_W'(MAX_LEVEL);
  end

  assign cin_vld[0] = in_acc;
  assign cin_tok[0] = '{empty: ~in_tuser, lat: lat_in, lon: lon_in, lvl: '0, left: lvl_in};

  genvar k;
  generate
    for (k = 0; k < NCELL; k++) begin : g_cell
      if (k > 0) begin : g_link
        assign cin_vld[k] = cout_vld[k-1];
        assign cin_tok[k] = cout_tok[k-1];
      end
      gtie_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ld    ((k == 0) ? (adv | in_acc) : adv),
        .vld_i (cin_vld[k]),
        .tok_i (cin_tok[k]),
        .vld_o (cout_vld[k]),
        .tok_o (cout_tok[k]),
        .res_o (cres[k])
      );
    end
  endgenerate

  // At most one cell holds a token, so an OR of the valid results selects it.
  always_comb begin
    busy = 1'b0;
    sel  = '0;
    for (int i = 0; i < NCELL; i++) begin
      busy = busy | cres[i].vld;
      if (cres[i].vld) sel = sel | cres[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sel.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.col, out_res_r.row, out_res_r.lvl};
  assign out_tuser  = out_res_r.empty;
  assign out_tlast  = out_res_r.last;

endmodule
`default_nettype wire

[rtl/gtie_checker.sv]
// Port-level checks for the tile index encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gtie_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [71:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);
  import gtie_pkg::*;

  // Stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An empty result is a lone, all-zero final result.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 16'd0))
    else $error("empty result malformed");

  // Digits and level stay in range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'(MAX_LEVEL)) && (out_tdata[7:4] < 4'(TILING))
      && (out_tdata[11:8] < 4'(TILING)) && (out_tdata[15:12] == 4'd0))
    else $error("result field out of range");

  // One item at a time: after an input transaction the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // A result right after a non-final one accepted belongs to the next level.
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid
      && (out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1))
    else $error("level sequence broken");

endmodule

bind geo_tile_index_encoder gtie_checker u_gtie_checker (.*);
`default_nettype wire
